>>> rtl/core/word_break_prefix_checker_unit_macros.svh
// assertion helpers for the word break checker
`ifndef WORD_BREAK_PREFIX_CHECKER_UNIT_MACROS_SVH
`define WORD_BREAK_PREFIX_CHECKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define WBPC_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("wbpc assertion failed");
`define WBPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wbpc assertion failed");
`define WBPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wbpc assertion failed");
`else
`define WBPC_ASSERT(label, expr)
`define WBPC_ASSERT_IMP(label, ante, cons)
`define WBPC_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/core/wbpc_pkg.sv
package wbpc_pkg;

    // fixed field widths
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = 16;
    localparam int USER_W = 3;
    localparam int OUT_W  = 24;
    localparam int PAD_W  = OUT_W - CNT_W - 2;

    // bit of tuser carrying the text start mark
    localparam int USER_START_BIT = 2;

    localparam logic [CNT_W-1:0] SEEN_MAX = {CNT_W{1'b1}};

    // input word kinds
    typedef enum logic [1:0] {
        ACT_DICT  = 2'd0,
        ACT_TEXT  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // command from the sequencer to the dictionary loader
    typedef struct packed {
        logic             take;
        logic             clear;
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_dict_cmd;

endpackage

>>> rtl/core/wbpc_ram.sv
module wbpc_ram #(
    parameter int WIDTH  = 133,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/wbpc_dict.sv
module wbpc_dict #(
    parameter int DICT_WORDS = 64,
    parameter int MAX_WORD   = 16,
    parameter int CNT_W      = $clog2(DICT_WORDS + 1),
    parameter int ADDR_W     = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1,
    parameter int ROW_W      = MAX_WORD * wbpc_pkg::SYM_W + wbpc_pkg::LEN_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbpc_pkg::t_dict_cmd i_cmd,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [ROW_W-1:0]    o_wdata,
    output logic [CNT_W-1:0]    o_count,
    output logic                o_overflow
);

    localparam int WIN_W = MAX_WORD * wbpc_pkg::SYM_W;

    logic [WIN_W-1:0]           r_row, n_row, w_shift_row;
    logic [wbpc_pkg::LEN_W-1:0] r_pend_len, n_pend_len, w_new_len;
    logic                       r_too_long, n_too_long;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_overflow, n_overflow;
    logic                       w_row_full;
    logic                       w_we;

    // pending word kept reversed: newest character in lane 0
    always_comb begin
        w_shift_row[wbpc_pkg::SYM_W-1:0] = i_cmd.sym;
        for (int j = 1; j < MAX_WORD; j++) begin
            w_shift_row[j*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W] =
                r_row[(j-1)*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W];
        end
    end

    assign w_row_full = (r_pend_len >= wbpc_pkg::LEN_W'(MAX_WORD));
    assign w_new_len  = w_row_full ? r_pend_len : r_pend_len + wbpc_pkg::LEN_W'(1);

    // character intake and commit at the end mark
    always_comb begin
        n_row      = r_row;
        n_pend_len = r_pend_len;
        n_too_long = r_too_long;
        n_count    = r_count;
        n_overflow = r_overflow;
        w_we       = 1'b0;
        if (i_cmd.clear) begin
            n_pend_len = '0;
            n_too_long = 1'b0;
            n_count    = '0;
            n_overflow = 1'b0;
        end else if (i_cmd.take) begin
            if (w_row_full) begin
                n_too_long = 1'b1;
            end else begin
                n_row      = w_shift_row;
                n_pend_len = w_new_len;
            end
            if (i_cmd.last) begin
                if (r_too_long || w_row_full || (r_count >= CNT_W'(DICT_WORDS))) begin
                    n_overflow = 1'b1;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
                n_pend_len = '0;
                n_too_long = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_len <= '0;
            r_too_long <= 1'b0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_pend_len <= n_pend_len;
            r_too_long <= n_too_long;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    // pending row is payload only
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    assign o_we       = w_we;
    assign o_waddr    = r_count[ADDR_W-1:0];
    assign o_wdata    = {w_new_len, n_row};
    assign o_count    = r_count;
    assign o_overflow = r_overflow;

endmodule

>>> rtl/core/wbpc_match.sv
module wbpc_match #(
    parameter int MAX_WORD = 16
) (
    input  logic [MAX_WORD*wbpc_pkg::SYM_W-1:0] i_row,
    input  logic [wbpc_pkg::LEN_W-1:0]          i_len,
    input  logic [MAX_WORD*wbpc_pkg::SYM_W-1:0] i_window,
    input  logic [MAX_WORD-1:0]                 i_hist,
    output logic                                o_hit
);

    logic w_chars_ok;
    logic w_hist_ok;

    // lane j of the stored row lines up with the character j back in the window
    always_comb begin
        w_chars_ok = 1'b1;
        w_hist_ok  = 1'b0;
        for (int j = 0; j < MAX_WORD; j++) begin
            if ((wbpc_pkg::LEN_W'(j) < i_len) &&
                (i_row[j*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W] !=
                 i_window[j*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W])) begin
                w_chars_ok = 1'b0;
            end
            if (i_len == wbpc_pkg::LEN_W'(j + 1)) begin
                w_hist_ok = i_hist[j];
            end
        end
    end

    // the prefix before the word must itself be breakable
    assign o_hit = (i_len != '0) && (i_len <= wbpc_pkg::LEN_W'(MAX_WORD)) &&
                   w_hist_ok && w_chars_ok;

endmodule

>>> rtl/core/word_break_prefix_checker_unit.sv
// Word break prefix checker.
// Input stream: tdata is the character byte, tlast marks the last character of a
// dictionary word, tuser[1:0] is the kind (dictionary character, text character,
// clear) and tuser[2] marks the first character of a new text.
// Output stream: one word per text character, tdata[0] breakable, tdata[16:1]
// prefix length (saturating), tdata[17] sticky dictionary overflow.
// Dictionary characters and clears give no output.
// A text character gets a valid output word after a scan (none with an empty
// dictionary): the dictionary rows are read from one RAM port and tested
// one word per cycle by a single compare unit, stopping at the first hit.
// The input is not ready during that scan.
// The result sits in an output register; the next item is accepted while it
// waits, and a new result waits in the final state until that register frees.
// Reset (synchronous, active low) and the clear kind empty the dictionary,
// drop the overflow flag and restart the text. The scan reads only committed
// rows, so the row RAM needs no clearing pass after reset.
module word_break_prefix_checker_unit #(
    parameter int DICT_WORDS = 64,
    parameter int MAX_WORD   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // symbol
    input  logic [wbpc_pkg::SYM_W-1:0]  i_s_axis_tdata,
    // word_end
    input  logic                        i_s_axis_tlast,
    // action[1:0], text_start[2]
    input  logic [wbpc_pkg::USER_W-1:0] i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // prefix_breakable[0], prefix_length[16:1], dict_overflow[17], zeros above
    output logic [wbpc_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    `include "word_break_prefix_checker_unit_macros.svh"

    localparam int CNT_W  = $clog2(DICT_WORDS + 1);
    localparam int ADDR_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int WIN_W  = MAX_WORD * wbpc_pkg::SYM_W;
    localparam int ROW_W  = WIN_W + wbpc_pkg::LEN_W;

    wbpc_pkg::t_state            r_state, n_state;
    wbpc_pkg::t_action           w_action;
    wbpc_pkg::t_dict_cmd         w_dict_cmd;
    logic                        w_s_fire;
    logic                        w_start;
    logic [WIN_W-1:0]            r_window, n_window, w_win_base;
    logic [MAX_WORD-1:0]         r_hist, n_hist;
    logic [wbpc_pkg::CNT_W-1:0]  r_seen, n_seen;
    logic [ADDR_W-1:0]           r_idx, n_idx;
    logic                        r_inflight, n_inflight;
    logic                        r_inflight_last, n_inflight_last;
    logic                        r_issue_done, n_issue_done;
    logic                        r_brk, n_brk;
    logic                        r_out_valid, n_out_valid;
    logic [wbpc_pkg::OUT_W-1:0]  r_out_data, n_out_data;
    logic                        w_out_load;
    logic                        w_ram_we;
    logic [ADDR_W-1:0]           w_ram_waddr;
    logic [ROW_W-1:0]            w_ram_wdata;
    logic                        w_ram_re;
    logic [ROW_W-1:0]            w_ram_rdata;
    logic [CNT_W-1:0]            w_word_count;
    logic                        w_overflow;
    logic                        w_hit;

    assign o_s_axis_tready = (r_state == wbpc_pkg::ST_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_action        = wbpc_pkg::t_action'(i_s_axis_tuser[1:0]);
    assign w_start         = i_s_axis_tuser[wbpc_pkg::USER_START_BIT];

    // dictionary loader command
    always_comb begin
        w_dict_cmd.take  = w_s_fire && (w_action == wbpc_pkg::ACT_DICT);
        w_dict_cmd.clear = w_s_fire && (w_action == wbpc_pkg::ACT_CLEAR);
        w_dict_cmd.last  = i_s_axis_tlast;
        w_dict_cmd.sym   = i_s_axis_tdata;
    end

    wbpc_dict #(
        .DICT_WORDS (DICT_WORDS),
        .MAX_WORD   (MAX_WORD),
        .CNT_W      (CNT_W),
        .ADDR_W     (ADDR_W),
        .ROW_W      (ROW_W)
    ) u_dict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_dict_cmd),
        .o_we       (w_ram_we),
        .o_waddr    (w_ram_waddr),
        .o_wdata    (w_ram_wdata),
        .o_count    (w_word_count),
        .o_overflow (w_overflow)
    );

    // one row per word: length above, reversed characters below
    wbpc_ram #(
        .WIDTH   (ROW_W),
        .DEPTH   (DICT_WORDS),
        .ADDR_W  (ADDR_W)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    wbpc_match #(
        .MAX_WORD (MAX_WORD)
    ) u_match (
        .i_row    (w_ram_rdata[WIN_W-1:0]),
        .i_len    (w_ram_rdata[ROW_W-1 -: wbpc_pkg::LEN_W]),
        .i_window (r_window),
        .i_hist   (r_hist),
        .o_hit    (w_hit)
    );

    // shift the new text character into the window
    assign w_win_base = w_start ? '0 : r_window;
    always_comb begin
        n_window = w_win_base;
        n_window[wbpc_pkg::SYM_W-1:0] = i_s_axis_tdata;
        for (int j = 1; j < MAX_WORD; j++) begin
            n_window[j*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W] =
                w_win_base[(j-1)*wbpc_pkg::SYM_W +: wbpc_pkg::SYM_W];
        end
    end

    assign w_out_load = (r_state == wbpc_pkg::ST_FIN) && (!r_out_valid || i_m_axis_tready);
    assign w_ram_re   = (r_state == wbpc_pkg::ST_SCAN) && !r_issue_done;

    // sequencer: accept, scan the rows one per cycle, then post the result
    always_comb begin
        n_state         = r_state;
        n_hist          = r_hist;
        n_seen          = r_seen;
        n_idx           = r_idx;
        n_inflight      = 1'b0;
        n_inflight_last = r_inflight_last;
        n_issue_done    = r_issue_done;
        n_brk           = r_brk;
        n_out_valid     = r_out_valid;
        n_out_data      = r_out_data;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            wbpc_pkg::ST_IDLE: begin
                if (w_s_fire) begin
                    case (w_action)
                        wbpc_pkg::ACT_TEXT: begin
                            n_hist = w_start ? MAX_WORD'(1) : r_hist;
                            if (w_start) begin
                                n_seen = wbpc_pkg::CNT_W'(1);
                            end else if (r_seen != wbpc_pkg::SEEN_MAX) begin
                                n_seen = r_seen + wbpc_pkg::CNT_W'(1);
                            end
                            n_idx        = '0;
                            n_issue_done = 1'b0;
                            n_brk        = 1'b0;
                            n_state      = (w_word_count == '0) ? wbpc_pkg::ST_FIN
                                                                : wbpc_pkg::ST_SCAN;
                        end
                        wbpc_pkg::ACT_CLEAR: begin
                            n_hist = MAX_WORD'(1);
                            n_seen = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wbpc_pkg::ST_SCAN: begin
                if (!r_issue_done) begin
                    n_inflight      = 1'b1;
                    n_inflight_last = (CNT_W'(r_idx) + CNT_W'(1) == w_word_count);
                    if (n_inflight_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
                if (r_inflight) begin
                    if (w_hit) begin
                        n_brk   = 1'b1;
                        n_state = wbpc_pkg::ST_FIN;
                    end else if (r_inflight_last) begin
                        n_state = wbpc_pkg::ST_FIN;
                    end
                end
            end
            wbpc_pkg::ST_FIN: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{wbpc_pkg::PAD_W{1'b0}}, w_overflow, r_seen, r_brk};
                    n_hist[0]   = r_brk;
                    for (int j = 1; j < MAX_WORD; j++) begin
                        n_hist[j] = r_hist[j-1];
                    end
                    n_state = wbpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wbpc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wbpc_pkg::ST_IDLE;
            r_window     <= '0;
            r_hist       <= MAX_WORD'(1);
            r_seen       <= '0;
            r_inflight   <= 1'b0;
            r_issue_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hist       <= n_hist;
            r_seen       <= n_seen;
            r_inflight   <= n_inflight;
            r_issue_done <= n_issue_done;
            r_out_valid  <= n_out_valid;
            if (w_s_fire && (w_action == wbpc_pkg::ACT_TEXT)) begin
                r_window <= n_window;
            end else if (w_s_fire && (w_action == wbpc_pkg::ACT_CLEAR)) begin
                r_window <= '0;
            end
        end
    end

    // scan bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        r_idx           <= n_idx;
        r_inflight_last <= n_inflight_last;
        r_brk           <= n_brk;
        r_out_data      <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `WBPC_ASSERT(a_count_bound, w_word_count <= CNT_W'(DICT_WORDS))
    `WBPC_ASSERT_IMP(a_out_from_fin, $rose(o_m_axis_tvalid), $past(r_state == wbpc_pkg::ST_FIN))
    `WBPC_ASSERT_NXT(a_hit_ends_scan, (r_state == wbpc_pkg::ST_SCAN) && r_inflight && w_hit,
                     (r_state == wbpc_pkg::ST_FIN) && r_brk)

endmodule

>>> tb/sv/word_break_prefix_checker_unit_test.sv
module word_break_prefix_checker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWORDS = 64;
    localparam int WLEN   = 16;
    localparam int ITEMS  = 1250;
    localparam int SETTLE = NWORDS + 16;

    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // one word headed for the input stream
    typedef struct {
        logic [1:0] kind;
        logic [7:0] sym;
        logic       last;
        logic       first;
        bit         hold;
        bit         brisk;
    } t_stream_word;

    // what one text character should give back
    typedef struct {
        logic        breakable;
        logic [15:0] length;
        logic        overflow;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [wbpc_pkg::SYM_W-1:0]  s_data  = '0;
    logic                        s_last  = 1'b0;
    logic [wbpc_pkg::USER_W-1:0] s_user  = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [wbpc_pkg::OUT_W-1:0]  m_data;

    t_stream_word stream_q [$];
    t_verdict     verdict_q [$];
    t_stream_word cur;
    int           fault_cnt = 0;
    int           gap       = 0;
    int           stall     = 0;
    bit           idle_ok   = 1'b1;
    bit           lull      = 1'b0;

    // predicted block state
    logic [7:0]      dict_sym [NWORDS][WLEN];
    int              dict_len [NWORDS];
    int              dict_cnt  = 0;
    int              part_len  = 0;
    bit              part_long = 1'b0;
    logic [7:0]      recent [WLEN];
    logic [WLEN-1:0] brk_hist = WLEN'(1);
    logic [15:0]     text_len = '0;
    bit              ovf      = 1'b0;

    // words known to be stored, used to build breakable text
    logic [7:0] pick_sym [NWORDS][WLEN];
    int         pick_len [NWORDS];
    int         pick_n = 0;
    logic [7:0] spell [WLEN+8];
    int         spell_n = 0;
    int         issued  = 0;

    always #6 i_clk = ~i_clk;

    word_break_prefix_checker_unit #(
        .DICT_WORDS(NWORDS),
        .MAX_WORD  (WLEN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        // symbol
        .i_s_axis_tdata (s_data),
        // word_end
        .i_s_axis_tlast (s_last),
        // action[1:0], text_start[2]
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        // prefix_breakable[0], prefix_length[16:1], dict_overflow[17]
        .o_m_axis_tdata (m_data)
    );

    // text history back to the empty prefix
    function automatic void restart_text();
        for (int i = 0; i < WLEN; i++) recent[i] = '0;
        brk_hist = WLEN'(1);
        text_len = '0;
    endfunction

    // fold one accepted word into the predicted state
    function automatic void predict_prefix(input t_stream_word w);
        t_verdict v;
        logic     hit;
        logic     same;
        int       len;
        if (w.kind == wbpc_pkg::ACT_DICT) begin
            if (part_len >= WLEN) begin
                part_long = 1'b1;
            end else begin
                if (dict_cnt < NWORDS) dict_sym[dict_cnt][part_len] = w.sym;
                part_len++;
            end
            if (w.last) begin
                if (part_long || dict_cnt >= NWORDS) begin
                    ovf = 1'b1;
                end else begin
                    dict_len[dict_cnt] = part_len;
                    dict_cnt++;
                end
                part_len  = 0;
                part_long = 1'b0;
            end
        end else if (w.kind == wbpc_pkg::ACT_CLEAR) begin
            dict_cnt  = 0;
            part_len  = 0;
            part_long = 1'b0;
            ovf       = 1'b0;
            restart_text();
        end else if (w.kind == wbpc_pkg::ACT_TEXT) begin
            if (w.first) restart_text();
            for (int i = WLEN - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = w.sym;
            hit = 1'b0;
            // first stored word that ends here on a breakable boundary
            for (int d = 0; d < dict_cnt; d++) begin
                len = dict_len[d];
                if (!hit && brk_hist[len-1]) begin
                    same = 1'b1;
                    for (int k = 0; k < len; k++) begin
                        if (dict_sym[d][k] != recent[len-1-k]) same = 1'b0;
                    end
                    hit = same;
                end
            end
            brk_hist = {brk_hist[WLEN-2:0], hit};
            if (text_len != 16'hFFFF) text_len++;
            v.breakable = hit;
            v.length    = text_len;
            v.overflow  = ovf;
            verdict_q.push_back(v);
        end
    endfunction

    function automatic void put(input logic [1:0] kind, input logic [7:0] sym,
                                input logic last, input logic first,
                                input bit hold = 1'b0, input bit brisk = 1'b0);
        t_stream_word w;
        w.kind  = kind;
        w.sym   = sym;
        w.last  = last;
        w.first = first;
        w.hold  = hold;
        w.brisk = brisk;
        stream_q.push_back(w);
        issued++;
    endfunction

    function automatic void spell_fill(input logic [7:0] ch, input int n);
        for (int i = 0; i < n; i++) spell[i] = ch;
        spell_n = n;
    endfunction

    // mostly a three-letter alphabet so that words meet in the text
    function automatic void spell_rand(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) spell[i] = 8'($urandom_range(0, 255));
            else spell[i] = 8'h61 + 8'($urandom_range(0, 2));
        end
        spell_n = n;
    endfunction

    function automatic void spell_pick();
        int w;
        w = $urandom_range(0, pick_n - 1);
        for (int i = 0; i < pick_len[w]; i++) spell[i] = pick_sym[w][i];
        spell_n = pick_len[w];
    endfunction

    function automatic void put_word();
        for (int i = 0; i < spell_n; i++) begin
            put(wbpc_pkg::ACT_DICT, spell[i], i == spell_n - 1, 1'($urandom_range(0, 1)));
        end
        if (spell_n <= WLEN && pick_n < NWORDS) begin
            for (int i = 0; i < spell_n; i++) pick_sym[pick_n][i] = spell[i];
            pick_len[pick_n] = spell_n;
            pick_n++;
        end
    endfunction

    function automatic void put_text(input bit fresh);
        for (int i = 0; i < spell_n; i++) begin
            put(wbpc_pkg::ACT_TEXT, spell[i], 1'($urandom_range(0, 1)), fresh && i == 0);
        end
    endfunction

    function automatic void put_clear(input bit hold);
        put(wbpc_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), hold);
        pick_n = 0;
    endfunction

    // input side: present queued words, with random gaps
    always @(posedge i_clk) begin : drive_proc
        t_stream_word nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            gap     <= 0;
        end else begin
            if (s_valid && s_ready) predict_prefix(cur);
            if (s_valid && !s_ready) begin
                // hold the word until taken
            end else if (gap != 0) begin
                gap     <= gap - 1;
                s_valid <= 1'b0;
            end else if (stream_q.size() != 0 &&
                         (!stream_q[0].hold || verdict_q.size() == 0)) begin
                nxt = stream_q.pop_front();
                cur     <= nxt;
                s_data  <= nxt.sym;
                s_last  <= nxt.last;
                s_user  <= {nxt.first, nxt.kind};
                s_valid <= 1'b1;
                idle_ok <= !nxt.brisk && stream_q.size() > 150 && !lull;
                if ($urandom_range(0, 99) == 0) lull <= !lull;
                if (idle_ok && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 16);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls, compare against the oldest prediction
    always @(posedge i_clk) begin : watch_proc
        t_verdict want;
        logic        got_brk;
        logic [15:0] got_len;
        logic        got_ovf;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall   <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_brk = m_data[0];
                got_len = m_data[wbpc_pkg::CNT_W:1];
                got_ovf = m_data[wbpc_pkg::CNT_W+1];
                if (verdict_q.size() == 0) begin
                    if (fault_cnt < 10)
                        $display("unexpected word: brk %0b len %0d ovf %0b",
                                 got_brk, got_len, got_ovf);
                    fault_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got_brk !== want.breakable || got_len !== want.length ||
                        got_ovf !== want.overflow) begin
                        if (fault_cnt < 10)
                            $display({"mismatch: exp brk %0b len %0d ovf %0b,",
                                      " got brk %0b len %0d ovf %0b"},
                                     want.breakable, want.length, want.overflow,
                                     got_brk, got_len, got_ovf);
                        fault_cnt++;
                    end
                end
            end
            if (stall != 0) begin
                stall   <= stall - 1;
                m_ready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 31) == 0) begin
                stall   <= $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stim_proc
        int  phase;
        int  r;
        bit  fresh;
        for (int i = 0; i < WLEN; i++) recent[i] = '0;

        // text straight after reset, no start mark, extreme bytes
        put(wbpc_pkg::ACT_TEXT, 8'h00, 1'b1, 1'b0);
        put(wbpc_pkg::ACT_TEXT, 8'hFF, 1'b0, 1'b0);
        put(ACT_UNUSED, 8'hA5, 1'b1, 1'b1);
        // words: zero byte, "a", "ab", longest, one too long
        spell_fill(8'h00, 1);
        put_word();
        spell_fill(8'h61, 1);
        put_word();
        spell[0] = 8'h61;
        spell[1] = 8'h62;
        spell_n  = 2;
        put_word();
        spell_fill(8'hFF, WLEN);
        put_word();
        spell_fill(8'h63, WLEN + 1);
        put_word();
        // "ab" then a zero byte as a fresh text
        spell[0] = 8'h61;
        spell[1] = 8'h62;
        spell[2] = 8'h00;
        spell_n  = 3;
        put_text(1'b1);
        // longest word spanning the whole window
        spell_fill(8'hFF, WLEN);
        put_text(1'b1);
        // word loaded in the middle of a text
        spell_fill(8'h78, 1);
        put_text(1'b1);
        put_word();
        put_text(1'b0);
        put_text(1'b1);
        // clear once the block is drained, then text with no start mark
        put_clear(1'b1);
        put(wbpc_pkg::ACT_TEXT, 8'h61, 1'b0, 1'b0);
        // long text running well past the window
        spell_fill(8'h61, 1);
        put_word();
        for (int i = 0; i < 4 * WLEN; i++)
            put(wbpc_pkg::ACT_TEXT, 8'h61, 1'b0, i == 0, 1'b0, 1'b1);
        put(wbpc_pkg::ACT_TEXT, 8'h61, 1'b0, 1'b1);

        // random phases: optional clear, words, then texts built from them
        issued = 0;
        phase  = 0;
        while (issued < ITEMS) begin
            if (phase == 0 || $urandom_range(0, 5) == 0)
                put_clear(phase == 0 || $urandom_range(0, 2) == 0);
            repeat (phase == 0 ? NWORDS + 6 : $urandom_range(1, 6)) begin
                r = $urandom_range(0, 19);
                if (phase == 0) spell_rand($urandom_range(1, 2));
                else if (r == 0) spell_rand($urandom_range(WLEN + 1, WLEN + 4));
                else if (r < 3) spell_rand($urandom_range(4, WLEN));
                else spell_rand($urandom_range(1, 3));
                put_word();
            end
            repeat ($urandom_range(1, 4)) begin
                fresh = $urandom_range(0, 3) != 0;
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        put(ACT_UNUSED, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end else if (r == 1) begin
                        spell_rand($urandom_range(1, 2));
                        put_word();
                    end else if (r == 2 || pick_n == 0) begin
                        spell_rand($urandom_range(1, 3));
                        put_text(fresh);
                        fresh = 1'b0;
                    end else begin
                        spell_pick();
                        put_text(fresh);
                        fresh = 1'b0;
                    end
                end
            end
            phase++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then let any stray word surface
        while (stream_q.size() != 0 || s_valid || verdict_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fault_cnt == 0 && verdict_q.size() == 0) begin
            $display("word_break_prefix_checker_unit_test passed");
        end else begin
            $display("word_break_prefix_checker_unit_test failed");
        end
        $finish;
    end

    // watchdog
    initial begin : limit_proc
        #40_000_000;
        $display("word_break_prefix_checker_unit_test failed");
        $finish;
    end

endmodule
